// ===== rtl/step_cadence_estimator_assert.svh =====
// Assertion macros for the step cadence estimator.
`ifndef STEP_CADENCE_ESTIMATOR_ASSERT_SVH
`define STEP_CADENCE_ESTIMATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SCE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sce_pkg.sv =====
// Shared widths, constants and register codes of the step cadence estimator.
`default_nettype none
package sce_pkg;

    localparam int STEP_BITS = 24;
    localparam int TIME_BITS = 32;

    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CAD_W    = 8;
    localparam int SPEED_W  = 10;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_W  = ((STEP_BITS + TIME_BITS + 7) / 8) * 8;
    localparam int OUT_W = ((CAD_W + SPEED_W + 7) / 8) * 8;

    // Numerator 2*delta*60000 + elapsed, and divisor 2*elapsed scaled by 2^8.
    localparam int MUL_K_W = 17;
    localparam int NUM_W   = ((STEP_BITS + MUL_K_W > TIME_BITS) ?
                              STEP_BITS + MUL_K_W : TIME_BITS) + 1;
    localparam int DIV_W   = TIME_BITS + 1 + CAD_W;
    localparam int CMP_W   = (NUM_W > DIV_W) ? NUM_W : DIV_W;
    localparam int CNT_W   = $clog2(STEP_BITS + 1);

    localparam logic [CMP_W-1:0] TWO_MS_PER_MIN = CMP_W'(120000);

    // Speed = (cadence*333 + 50) / 100, division done as *83887 >> 23, exact for
    // every dividend up to 255*333 + 50.
    localparam int Y_W         = 17;
    localparam int Z_W         = 33;
    localparam int RECIP_SHIFT = 23;
    localparam logic [Y_W-1:0]     SPEED_NUM  = Y_W'(333);
    localparam logic [Y_W-1:0]     SPEED_HALF = Y_W'(50);
    localparam logic [Z_W-1:0]     SPEED_RECIP = Z_W'(83887);
    localparam logic [SPEED_W-1:0] SPEED_MAX  = SPEED_W'(849);
    localparam logic [CAD_W-1:0]   CADENCE_MAX = CAD_W'(255);

    localparam logic [CFG_W-1:0] WINDOW_MS_RST    = CFG_W'(4000);
    localparam logic [CFG_W-1:0] IDLE_TIMEOUT_RST = CFG_W'(4500);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_MS    = 1'b0,
        CFG_IDLE_TIMEOUT = 1'b1
    } t_cfg_idx;

endpackage
`default_nettype wire

// ===== rtl/step_cadence_estimator.sv =====
// Step cadence estimator: windowed cadence and speed from pedometer readings.
// A reading passes S_CHECK and S_EVAL; when the window closes, it then runs the bit-serial
// multiply (S_MUL) and divide (S_DIV), then S_SPD1, S_SPD2 and S_OUT into the output
// register. A restarting reading returns from S_CHECK to S_IDLE and gives no result.
// Input is taken only in S_IDLE, so a reading is finished before the next is taken.
// Reset (i_rst_n low, synchronous): no window open, cadence 0, registers to defaults.
`default_nettype none
`include "step_cadence_estimator_assert.svh"
module step_cadence_estimator
    import sce_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Configuration write channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    // Input stream
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  wire logic [IN_W-1:0]      i_s_axis_tdata,   // step_total, time_ms
    // Result stream
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    output logic [OUT_W-1:0]          o_m_axis_tdata,   // cadence_spm, speed_units, zero pad
    output logic                      o_m_axis_tuser    // window_closed
);

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_EVAL, S_MUL, S_DIV, S_SPD1, S_SPD2, S_OUT
    } t_state;

    t_state r_state;

    // Configuration
    logic [CFG_W-1:0] r_window_ms;
    logic [CFG_W-1:0] r_idle_to;

    // Window state
    logic                 r_primed;
    logic [STEP_BITS-1:0] r_wsteps;
    logic [TIME_BITS-1:0] r_start;
    logic [TIME_BITS-1:0] r_last;
    logic [CAD_W-1:0]     r_cadence;

    // Current reading and derived values
    logic [STEP_BITS-1:0] r_total;
    logic [TIME_BITS-1:0] r_now;
    logic [STEP_BITS-1:0] r_delta;
    logic [TIME_BITS-1:0] r_elapsed;
    logic [TIME_BITS-1:0] r_idle_diff;
    logic                 r_rising;
    logic                 r_idle_q;
    logic                 r_closed;

    // Serial multiply / divide datapath
    logic [CMP_W-1:0]     r_rem;
    logic [CMP_W-1:0]     r_mul_a;
    logic [STEP_BITS-1:0] r_mul_b;
    logic [CMP_W-1:0]     r_dv;
    logic [CAD_W-1:0]     r_q;
    logic                 r_sat;
    logic [CNT_W-1:0]     r_cnt;

    // Speed products
    logic [Y_W-1:0] r_y;
    logic [Z_W-1:0] r_z;

    // Output register
    logic               r_m_valid;
    logic [OUT_W-1:0]   r_m_data;
    logic               r_m_user;

    // Combinational helpers
    logic [STEP_BITS:0]   n_delta;
    logic [CFG_W-1:0]     w_win;
    logic                 w_closing;
    logic                 w_idle;
    logic                 w_ge;
    logic [CAD_W-1:0]     w_q_next;
    logic                 w_out_free;

    always_comb begin
        // A borrow out of this subtract means the total dropped.
        n_delta    = {1'b0, r_total} - {1'b0, r_wsteps};
        w_win      = (r_window_ms == '0) ? CFG_W'(1) : r_window_ms;
        w_closing  = r_elapsed >= TIME_BITS'(w_win);
        // A rising total moved the last step to now, so it can never be idle.
        w_idle     = !r_rising && (r_idle_diff > TIME_BITS'(r_idle_to));
        w_ge       = r_rem >= r_dv;
        w_q_next   = {r_q[CAD_W-2:0], w_ge};
        w_out_free = !r_m_valid || i_m_axis_tready;
    end

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tuser  = r_m_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_window_ms <= WINDOW_MS_RST;
            r_idle_to   <= IDLE_TIMEOUT_RST;
            r_primed    <= 1'b0;
            r_wsteps    <= '0;
            r_start     <= '0;
            r_last      <= '0;
            r_cadence   <= '0;
            r_m_valid   <= 1'b0;
            r_cnt       <= '0;
        end else begin
            // Register writes; the user must issue them only while the block is idle, the block does not enforce it.
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_WINDOW_MS:    r_window_ms <= i_cfg_data;
                    CFG_IDLE_TIMEOUT: r_idle_to   <= i_cfg_data;
                    default: ;
                endcase
            end

            // Drop the result once the sink takes it; S_OUT reloads it on its own.
            if (i_m_axis_tready && r_state != S_OUT) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_total <= i_s_axis_tdata[STEP_BITS-1:0];
                        r_now   <= i_s_axis_tdata[STEP_BITS +: TIME_BITS];
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (!r_primed || n_delta[STEP_BITS]) begin
                        // First reading or dropped total: restart, no result.
                        r_primed <= 1'b1;
                        r_wsteps <= r_total;
                        r_start  <= r_now;
                        r_last   <= r_now;
                        r_state  <= S_IDLE;
                    end else begin
                        r_delta     <= n_delta[STEP_BITS-1:0];
                        r_rising    <= (n_delta[STEP_BITS-1:0] != '0);
                        r_elapsed   <= r_now - r_start;
                        r_idle_diff <= r_now - r_last;
                        if (n_delta[STEP_BITS-1:0] != '0) begin
                            r_last <= r_now;
                        end
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_idle_q <= w_idle;
                    if (w_closing) begin
                        // Close the window; start 2*delta*60000 + elapsed.
                        r_wsteps <= r_total;
                        r_start  <= r_now;
                        r_closed <= 1'b1;
                        r_rem    <= CMP_W'(r_elapsed);
                        r_mul_a  <= TWO_MS_PER_MIN;
                        r_mul_b  <= r_delta;
                        r_cnt    <= '0;
                        r_state  <= S_MUL;
                    end else begin
                        r_closed <= 1'b0;
                        if (w_idle) begin
                            r_cadence <= '0;
                        end
                        r_state <= S_SPD1;
                    end
                end
                S_MUL: begin
                    // One multiplier bit per cycle, least significant first.
                    if (r_mul_b[0]) begin
                        r_rem <= r_rem + r_mul_a;
                    end
                    r_mul_a <= r_mul_a << 1;
                    r_mul_b <= r_mul_b >> 1;
                    if (r_cnt == CNT_W'(STEP_BITS - 1)) begin
                        r_cnt   <= '0;
                        r_dv    <= CMP_W'({r_elapsed, 1'b0}) << CAD_W;
                        r_state <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_DIV: begin
                    // First step detects a quotient above 255, then 8 quotient bits.
                    if (r_cnt == '0) begin
                        r_sat <= w_ge;
                    end else begin
                        if (w_ge) begin
                            r_rem <= r_rem - r_dv;
                        end
                        r_q <= w_q_next;
                    end
                    r_dv <= r_dv >> 1;
                    if (r_cnt == CNT_W'(CAD_W)) begin
                        r_cnt <= '0;
                        if (r_idle_q) begin
                            r_cadence <= '0;
                        end else if (r_sat) begin
                            r_cadence <= CADENCE_MAX;
                        end else begin
                            r_cadence <= w_q_next;
                        end
                        r_state <= S_SPD1;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_SPD1: begin
                    r_y     <= Y_W'(Y_W'(r_cadence) * SPEED_NUM) + SPEED_HALF;
                    r_state <= S_SPD2;
                end
                S_SPD2: begin
                    r_z     <= Z_W'(Z_W'(r_y) * SPEED_RECIP);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // Hold until the output register is free.
                    if (w_out_free) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= OUT_W'({r_z[RECIP_SHIFT +: SPEED_W], r_cadence});
                        r_m_user  <= r_closed;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Input is held off while the serial arithmetic runs.
    `SCE_ASSERT_NOW(a_busy_no_accept, i_clk, i_rst_n,
        (r_state == S_MUL || r_state == S_DIV), !o_s_axis_tready,
        "input accepted during serial arithmetic")

    // Speed from the reciprocal multiply stays within its range.
    `SCE_ASSERT_NOW(a_speed_range, i_clk, i_rst_n,
        o_m_axis_tvalid, (o_m_axis_tdata[CAD_W +: SPEED_W] <= SPEED_MAX),
        "speed out of range")

    // An idle reading without a window close forces cadence to zero.
    `SCE_ASSERT_NEXT(a_idle_zero, i_clk, i_rst_n,
        (r_state == S_EVAL && w_idle && !w_closing), (r_cadence == '0),
        "idle reading kept a nonzero cadence")

endmodule
`default_nettype wire
